### hw/rtl/goldbach_partition_counter_defines.svh
// Assertion macros used by the checker file.
`ifndef GOLDBACH_PARTITION_COUNTER_DEFINES_SVH
`define GOLDBACH_PARTITION_COUNTER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define GPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/gpc_pkg.sv
package gpc_pkg;
  localparam int unsigned MaxMagnitude = 4095;
  localparam int unsigned PrimeDepth   = 1024;
  localparam int unsigned SieveDepth   = MaxMagnitude + 1;
  localparam int unsigned SieveAw      = $clog2(SieveDepth);
  localparam int unsigned PrimeAw      = $clog2(PrimeDepth);
  localparam int unsigned PrimeW       = $clog2(MaxMagnitude + 1);
  localparam int unsigned TotalW       = $clog2(PrimeDepth + 1);
  localparam int unsigned ValueW       = 13;
  localparam int unsigned MagW         = 13;
  localparam int unsigned CountW       = 18;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned NaLimit      = 5;

  localparam logic [CountW-1:0]  CountMax = '1;
  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StNa     = 2'd1;
  localparam logic [StatusW-1:0] StRange  = 2'd2;
endpackage

### hw/rtl/gpc_ram.sv
module gpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/goldbach_partition_counter.sv
// Goldbach partition counter. Each request carries a signed value whose magnitude m is
// decomposed: for even m the result counts prime pairs p<=q with p+q=m, for odd m prime
// triples p<=q<=r with p+q+r=m, saturating at 2^18-1. m<=5 returns status "not
// applicable", m above MaxMagnitude returns "out of range", both with count 0. One
// request is worked at a time; value_stall_o is high from acceptance until the result
// has been taken. The time per request is set by the sieve and prime-list memories,
// each with one read and one write port: clearing and crossing out the sieve,
// collecting primes, and the count pass over the primes for pairs or over the (p,q)
// candidates for triples. A finished result sits in an output register and is held
// until the consumer takes it.
module goldbach_partition_counter
  import gpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     value_valid_i,
  output logic                     value_stall_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     result_valid_o,
  input  logic                     result_stall_i,
  output logic [CountW-1:0]        sum_count_o,
  output logic [StatusW-1:0]       status_o,
  output logic                     used_triples_o
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SInit  = 4'd1;  // set marks 2..m, clear 0..1
  localparam logic [3:0] SOutRd = 4'd2;  // read mark i
  localparam logic [3:0] SOutCk = 4'd3;  // decide whether i is prime
  localparam logic [3:0] SCross = 4'd4;  // clear multiples of i
  localparam logic [3:0] SColRd = 4'd5;  // collect primes into list
  localparam logic [3:0] SColCk = 4'd6;
  localparam logic [3:0] SPRd   = 4'd7;  // read prime_list[i]
  localparam logic [3:0] SPWt   = 4'd8;
  localparam logic [3:0] SQRd   = 4'd9;  // read prime_list[j] (triples)
  localparam logic [3:0] SQWt   = 4'd10;
  localparam logic [3:0] SMark  = 4'd11; // read sieve at complement
  localparam logic [3:0] SMkWt  = 4'd12;
  localparam logic [3:0] SDone  = 4'd13;

  logic [3:0]         st_q, st_d;
  logic [MagW-1:0]    m_q, m_d;
  logic [MagW:0]      i_q, i_d, j_q, j_d;  // sieve index / stride walker
  logic [TotalW-1:0]  total_q, total_d, pi_q, pi_d, pj_q, pj_d;
  logic [MagW-1:0]    p_q, p_d, r_q, r_d, top_q, top_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               tri_q, tri_d, out_v_q, out_v_d;

  logic               sv_we, sv_wd, sv_rd;
  logic [SieveAw-1:0] sv_wa, sv_ra;
  logic               pl_we;
  logic [PrimeAw-1:0] pl_wa, pl_ra;
  logic [PrimeW-1:0]  pl_wd, pl_rd;

  logic [MagW-1:0] mag;
  assign mag = value_i[ValueW-1] ? MagW'(-value_i) : MagW'(value_i);

  gpc_ram #(.Width(1), .Depth(SieveDepth)) u_sieve (
    .clk_i, .we_i(sv_we), .waddr_i(sv_wa), .wdata_i(sv_wd),
    .raddr_i(sv_ra), .rdata_o(sv_rd)
  );
  gpc_ram #(.Width(PrimeW), .Depth(PrimeDepth)) u_plist (
    .clk_i, .we_i(pl_we), .waddr_i(pl_wa), .wdata_i(pl_wd),
    .raddr_i(pl_ra), .rdata_o(pl_rd)
  );

  assign value_stall_o  = (st_q != SIdle) || out_v_q;
  assign result_valid_o = out_v_q;
  assign sum_count_o    = cnt_q;
  assign status_o       = status_q;
  assign used_triples_o = tri_q;

  always_comb begin
    st_d = st_q; m_d = m_q; i_d = i_q; j_d = j_q; total_d = total_q;
    pi_d = pi_q; pj_d = pj_q; p_d = p_q; r_d = r_q; top_d = top_q;
    cnt_d = cnt_q; status_d = status_q; tri_d = tri_q; out_v_d = out_v_q;
    sv_we = 1'b0; sv_wa = i_q[SieveAw-1:0]; sv_wd = 1'b0; sv_ra = i_q[SieveAw-1:0];
    pl_we = 1'b0; pl_wa = total_q[PrimeAw-1:0]; pl_wd = PrimeW'(i_q);
    pl_ra = pi_q[PrimeAw-1:0];
    if (out_v_q && !result_stall_i) out_v_d = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (value_valid_i && !out_v_q) begin
          m_d = mag; cnt_d = '0; tri_d = 1'b0; i_d = '0;
          if (mag <= MagW'(NaLimit)) begin
            status_d = StNa; st_d = SDone;
          end else if ({1'b0, mag} > (MagW+1)'(MaxMagnitude)) begin
            status_d = StRange; st_d = SDone;
          end else begin
            status_d = StOk; st_d = SInit;
          end
        end
      end
      SInit: begin
        sv_we = 1'b1; sv_wd = (i_q >= (MagW+1)'(2));
        if (i_q == {1'b0, m_q}) begin
          i_d = (MagW+1)'(2); st_d = SOutRd;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      SOutRd: begin
        if (i_q > {1'b0, m_q}) begin
          i_d = (MagW+1)'(2); total_d = '0; st_d = SColRd;
        end else begin
          st_d = SOutCk;
        end
      end
      SOutCk: begin
        if (sv_rd) begin
          j_d = i_q + i_q; st_d = SCross;
        end else begin
          i_d = i_q + 1'b1; st_d = SOutRd;
        end
      end
      SCross: begin
        if (j_q > {1'b0, m_q}) begin
          i_d = i_q + 1'b1; st_d = SOutRd;
        end else begin
          sv_we = 1'b1; sv_wa = j_q[SieveAw-1:0]; sv_wd = 1'b0;
          j_d = j_q + i_q;
        end
      end
      SColRd: begin
        if (i_q > {1'b0, m_q}) begin
          pi_d = '0; tri_d = m_q[0];
          st_d = (total_q == '0) ? SDone : SPRd;
        end else begin
          st_d = SColCk;
        end
      end
      SColCk: begin
        if (sv_rd && total_q < TotalW'(PrimeDepth)) begin
          pl_we = 1'b1; total_d = total_q + 1'b1; top_d = MagW'(i_q);
        end
        i_d = i_q + 1'b1; st_d = SColRd;
      end
      SPRd: begin
        if (pi_q == total_q) begin
          st_d = SDone;
        end else begin
          st_d = SPWt;
        end
      end
      SPWt: begin
        p_d = MagW'(pl_rd);
        if (!tri_q) begin
          r_d = m_q - MagW'(pl_rd);
          if (MagW'(pl_rd) <= m_q - MagW'(pl_rd)) begin
            st_d = SMark;
          end else begin
            pi_d = pi_q + 1'b1; st_d = SPRd;
          end
        end else begin
          pj_d = pi_q; st_d = SQRd;
        end
      end
      SQRd: begin
        pl_ra = pj_q[PrimeAw-1:0];
        if (pj_q == total_q) begin
          pi_d = pi_q + 1'b1; st_d = SPRd;
        end else begin
          st_d = SQWt;
        end
      end
      SQWt: begin
        if (p_q + MagW'(pl_rd) >= m_q) begin
          pi_d = pi_q + 1'b1; st_d = SPRd;
        end else begin
          r_d = m_q - p_q - MagW'(pl_rd);
          if (m_q - p_q - MagW'(pl_rd) >= MagW'(pl_rd)) begin
            st_d = SMark;
          end else begin
            pj_d = pj_q + 1'b1; st_d = SQRd;
          end
        end
      end
      SMark: begin
        sv_ra = r_q[SieveAw-1:0];
        st_d = SMkWt;
      end
      SMkWt: begin
        if (sv_rd && r_q <= top_q && r_q <= m_q && cnt_q != CountMax) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (tri_q) begin
          pj_d = pj_q + 1'b1; st_d = SQRd;
        end else begin
          pi_d = pi_q + 1'b1; st_d = SPRd;
        end
      end
      SDone: begin
        if (!out_v_q) begin
          out_v_d = 1'b1; st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; out_v_q <= 1'b0; total_q <= '0; cnt_q <= '0;
      status_q <= StOk; tri_q <= 1'b0;
    end else begin
      st_q <= st_d; out_v_q <= out_v_d; total_q <= total_d; cnt_q <= cnt_d;
      status_q <= status_d; tri_q <= tri_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; i_q <= i_d; j_q <= j_d; pi_q <= pi_d; pj_q <= pj_d;
    p_q <= p_d; r_q <= r_d; top_q <= top_d;
  end
endmodule

### hw/rtl/gpc_checker.sv
`include "goldbach_partition_counter_defines.svh"

module gpc_checker
  import gpc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               value_valid_i,
  input logic               value_stall_o,
  input logic               result_valid_o,
  input logic               result_stall_i,
  input logic [CountW-1:0]  sum_count_o,
  input logic [StatusW-1:0] status_o,
  input logic               used_triples_o
);
  `GPC_ASSERT_IMP(a_status_legal, clk_i, rst_ni, result_valid_o,
    status_o == StOk || status_o == StNa || status_o == StRange)
  `GPC_ASSERT_IMP(a_special_zero, clk_i, rst_ni, result_valid_o && status_o != StOk,
    sum_count_o == '0 && !used_triples_o)
  `GPC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, value_valid_i && !value_stall_o,
    value_stall_o)
  `GPC_ASSERT_IMP(a_one_in_flight, clk_i, rst_ni, result_valid_o, value_stall_o)
endmodule

bind goldbach_partition_counter gpc_checker u_gpc_checker (.*);
